[rtl/fbrs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fbrs_pkg;

   // Field widths
   localparam int MODE_W    = 2;
   localparam int BYTE_W    = 8;
   localparam int VALUE_W   = 5;
   localparam int INDEX_W   = 12;
   localparam int COUNT_W   = 13;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 13;

   // Run length ceiling
   localparam logic [COUNT_W-1:0] MAX_SAMPLES = COUNT_W'(4096);

   // Reset values of the control registers
   localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RST = COUNT_W'(4096);
   localparam logic [VALUE_W-1:0] REJECT_VALUE_RST = VALUE_W'(31);

   // Held-bit store: at most four bits survive a transaction
   localparam int HOLD_W     = 4;
   localparam int HOLD_CNT_W = 3;
   localparam int MERGE_W    = 12;

   // Result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_START = 2'd0,
      MODE_BYTE  = 2'd1,
      MODE_PAD   = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_COUNT = 1'd0,
      CSR_REJECT_VALUE = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
      logic               last;
   } sample_type;

endpackage

`default_nettype wire

[rtl/fbrs_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface fbrs_req_if;
   logic                           valid;
   logic                           ready;
   logic [fbrs_pkg::MODE_W-1:0]    mode;
   logic [fbrs_pkg::BYTE_W-1:0]    byte_value;

   modport source (output valid, output mode, output byte_value, input ready);
   modport sink   (input valid, input mode, input byte_value, output ready);
endinterface

`default_nettype wire

[rtl/fbrs_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface fbrs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [fbrs_pkg::VALUE_W-1:0]   sample_value;
   logic [fbrs_pkg::INDEX_W-1:0]   sample_index;
   logic                           last_sample;

   modport source (output valid, output sample_value, output sample_index,
                   output last_sample, input ready);
   modport sink   (input valid, input sample_value, input sample_index,
                   input last_sample, output ready);
endinterface

`default_nettype wire

[rtl/fbrs_csr_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface fbrs_csr_if;
   logic                             valid;
   logic                             ready;
   logic [fbrs_pkg::CSR_IDX_W-1:0]   reg_index;
   logic [fbrs_pkg::CSR_DAT_W-1:0]   wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

[rtl/five_bit_rejection_sampler.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake     Payload
// req_bus   in   valid/ready   mode[1:0], byte_value[7:0]
// rsp_bus   out  valid/ready   sample_value[4:0], sample_index[11:0], last_sample
// csr_bus   in   valid/ready   reg_index[0], wr_data[12:0] (always ready)
//
// A request transaction lands in an input register; once the queue has room it
// is processed against the held bits and up to two samples are pushed into a
// four-entry result queue. Sustained rate: one transaction a cycle while each
// yields at most one sample and rsp_bus does not stall; a byte yielding two
// samples is paced by the one-per-cycle result channel draining the queue.
// Stalls on rsp_bus fill the queue and then hold the input register, which in
// turn drops req_bus.ready.
// Synchronous active-high reset clears the held bits, the sample counter, the
// queue and restores sample_count to 4096 and reject_value to 31.

module five_bit_rejection_sampler (
   input  wire              clock,
   input  wire              reset,
   fbrs_req_if.sink         req_bus,
   fbrs_rsp_if.source       rsp_bus,
   fbrs_csr_if.sink         csr_bus
);

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   logic [fbrs_pkg::COUNT_W-1:0] sample_count_ff;
   logic [fbrs_pkg::VALUE_W-1:0] reject_value_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= fbrs_pkg::SAMPLE_COUNT_RST;
         reject_value_ff <= fbrs_pkg::REJECT_VALUE_RST;
      end else if (csr_bus.valid) begin
         case (fbrs_pkg::csr_index_type'(csr_bus.reg_index))
            fbrs_pkg::CSR_SAMPLE_COUNT: begin
               sample_count_ff <= csr_bus.wr_data;
            end
            fbrs_pkg::CSR_REJECT_VALUE: begin
               reject_value_ff <= csr_bus.wr_data[fbrs_pkg::VALUE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Effective run length: clamp to the ceiling
   logic [fbrs_pkg::COUNT_W-1:0] run_limit;
   assign run_limit = (sample_count_ff > fbrs_pkg::MAX_SAMPLES) ?
                      fbrs_pkg::MAX_SAMPLES : sample_count_ff;

   // ------------------------------------------------------------------
   // Input register
   // ------------------------------------------------------------------
   logic                          in_valid_ff;
   logic [fbrs_pkg::MODE_W-1:0]   in_mode_ff;
   logic [fbrs_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                          proc_fire;

   // Result queue occupancy
   logic [fbrs_pkg::FIFO_CNT_W-1:0] fifo_count_ff;
   logic [fbrs_pkg::FIFO_CNT_W-1:0] fifo_count_in;

   // Process only with room for two samples in the queue
   assign proc_fire     = in_valid_ff &&
                          (fifo_count_ff <= fbrs_pkg::FIFO_CNT_W'(fbrs_pkg::FIFO_DEPTH - 2));
   assign req_bus.ready = !in_valid_ff || proc_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_mode_ff <= req_bus.mode;
         in_byte_ff <= req_bus.byte_value;
      end
   end

   // ------------------------------------------------------------------
   // Sampling state
   // ------------------------------------------------------------------
   logic [fbrs_pkg::HOLD_W-1:0]     hold_ff, hold_in;
   logic [fbrs_pkg::HOLD_CNT_W-1:0] hold_cnt_ff, hold_cnt_in;
   logic [fbrs_pkg::COUNT_W-1:0]    produced_ff, produced_in;

   logic [fbrs_pkg::MERGE_W-1:0]    merged;
   logic [fbrs_pkg::VALUE_W-1:0]    cand0, cand1;
   logic                            two_cand;
   logic                            room0;
   logic                            room1;
   logic                            emit0, emit1;
   logic [1:0]                      num_wr;
   fbrs_pkg::sample_type            wr_first, wr_second;
   logic [fbrs_pkg::COUNT_W-1:0]    produced_p1;
   logic [fbrs_pkg::COUNT_W-1:0]    produced_p2;

   // Append the byte above the held bits; held bits above the count are zero
   assign merged   = fbrs_pkg::MERGE_W'(hold_ff) |
                     (fbrs_pkg::MERGE_W'(in_byte_ff) << hold_cnt_ff);
   assign cand0    = merged[4:0];
   assign cand1    = merged[9:5];
   // Count plus eight reaches ten when at least two bits were held
   assign two_cand = (hold_cnt_ff >= fbrs_pkg::HOLD_CNT_W'(2));

   assign produced_p1 = produced_ff + fbrs_pkg::COUNT_W'(1);
   assign produced_p2 = produced_ff + fbrs_pkg::COUNT_W'(2);
   assign room0       = (produced_ff < run_limit);

   always_comb begin
      hold_in     = hold_ff;
      hold_cnt_in = hold_cnt_ff;
      produced_in = produced_ff;
      num_wr      = 2'd0;
      emit0       = 1'b0;
      emit1       = 1'b0;
      room1       = 1'b0;
      wr_first    = '0;
      wr_second   = '0;

      wr_first.index  = produced_ff[fbrs_pkg::INDEX_W-1:0];
      wr_first.last   = (produced_p1 == run_limit);
      wr_second.index = produced_p1[fbrs_pkg::INDEX_W-1:0];
      wr_second.last  = (produced_p2 == run_limit);
      wr_second.value = cand1;

      if (proc_fire) begin
         case (fbrs_pkg::mode_type'(in_mode_ff))
            fbrs_pkg::MODE_START: begin
               hold_in     = '0;
               hold_cnt_in = '0;
               produced_in = '0;
            end
            fbrs_pkg::MODE_PAD: begin
               // While the run has room: drop held bits and emit one zero sample
               if (room0) begin
                  hold_in        = '0;
                  hold_cnt_in    = '0;
                  wr_first.value = '0;
                  num_wr         = 2'd1;
                  produced_in    = produced_p1;
               end
            end
            fbrs_pkg::MODE_BYTE: begin
               if (room0) begin
                  if (two_cand) begin
                     hold_in     = fbrs_pkg::HOLD_W'(merged[11:10]);
                     hold_cnt_in = hold_cnt_ff - fbrs_pkg::HOLD_CNT_W'(2);
                  end else begin
                     hold_in     = merged[8:5];
                     hold_cnt_in = hold_cnt_ff + fbrs_pkg::HOLD_CNT_W'(3);
                  end
                  emit0 = (cand0 != reject_value_ff);
                  // Second candidate sees the count after the first
                  room1 = emit0 ? (produced_p1 < run_limit) : 1'b1;
                  emit1 = two_cand && (cand1 != reject_value_ff) && room1;
                  wr_first.value = emit0 ? cand0 : cand1;
                  if (!emit0) begin
                     wr_first.last = (produced_p1 == run_limit);
                  end
                  num_wr      = {1'b0, emit0} + {1'b0, emit1};
                  produced_in = produced_ff + fbrs_pkg::COUNT_W'(num_wr);
               end
            end
            default: begin
               // Unused code: leave everything unchanged
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff     <= '0;
         hold_cnt_ff <= '0;
         produced_ff <= '0;
      end else begin
         hold_ff     <= hold_in;
         hold_cnt_ff <= hold_cnt_in;
         produced_ff <= produced_in;
      end
   end

   // ------------------------------------------------------------------
   // Result queue
   // ------------------------------------------------------------------
   fbrs_pkg::sample_type            fifo_ff [fbrs_pkg::FIFO_DEPTH];
   logic [fbrs_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [fbrs_pkg::FIFO_PTR_W-1:0] wr_ptr_p1;
   logic                            pop;
   fbrs_pkg::sample_type            head;

   assign wr_ptr_p1 = wr_ptr_ff + fbrs_pkg::FIFO_PTR_W'(1);
   assign pop       = rsp_bus.valid && rsp_bus.ready;
   assign fifo_count_in = fifo_count_ff + fbrs_pkg::FIFO_CNT_W'(num_wr) -
                          fbrs_pkg::FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (num_wr != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= wr_first;
      end
      if (num_wr == 2'd2) begin
         fifo_ff[wr_ptr_p1] <= wr_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
      end else begin
         wr_ptr_ff     <= wr_ptr_ff + fbrs_pkg::FIFO_PTR_W'(num_wr);
         rd_ptr_ff     <= rd_ptr_ff + fbrs_pkg::FIFO_PTR_W'(pop);
         fifo_count_ff <= fifo_count_in;
      end
   end

   assign head                 = fifo_ff[rd_ptr_ff];
   assign rsp_bus.valid        = (fifo_count_ff != '0);
   assign rsp_bus.sample_value = head.value;
   assign rsp_bus.sample_index = head.index;
   assign rsp_bus.last_sample  = head.last;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_count_ff <= fbrs_pkg::FIFO_CNT_W'(fbrs_pkg::FIFO_DEPTH))
      else $error("result queue overfilled");

   a_hold_small: assert property (@(posedge clock) disable iff (reset)
      hold_cnt_ff <= fbrs_pkg::HOLD_CNT_W'(4))
      else $error("held bit count reached a full candidate");

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !proc_fire |=> in_valid_ff && $stable(in_mode_ff))
      else $error("stalled input transaction lost");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (fifo_count_ff == '0) && !in_valid_ff && (produced_ff == '0))
      else $error("state not cleared by reset");

endmodule

`default_nettype wire
